// ===== hw/rtl/bis_pkg.sv =====
// ============================================================================
// Bilinear image scaler package
// Shared constants, codes, types and helper functions of the scaler.
// ============================================================================
package bis_pkg;

  // Frame geometry and fixed-point format
  localparam int MaxCols  = 512;
  localparam int MaxRows  = 512;
  localparam int FracBits = 16;

  // Derived widths
  localparam int CoordW   = $clog2(MaxCols);          // column and row index
  localparam int DimW     = CoordW + 1;               // configured dimension
  localparam int ProdW    = 2 * CoordW;               // (src-1) * t
  localparam int QuotW    = CoordW + FracBits;        // fixed-point coordinate
  localparam int DivCntW  = $clog2(QuotW);
  localparam int AddrW    = 2 * CoordW;               // {row, col}
  localparam int ChanW    = 8;
  localparam int PixW     = 3 * ChanW;
  localparam int WeightW  = FracBits + 1;             // 0 .. 1.0
  localparam int LineW    = ChanW + FracBits;         // one-direction blend
  localparam int SumW     = ChanW + 2 * FracBits;     // two-direction blend
  localparam int FixOne   = 1 << FracBits;
  localparam int InDataW  = 48;
  localparam int OutDataW = 24;
  localparam int CfgIdxW  = 2;

  // Command codes carried in tuser
  localparam logic CmdWrite   = 1'b0;
  localparam logic CmdRequest = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegSrcWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSrcHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegDstWidth  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegDstHeight = 2'd3;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_RD00,
    ST_RD10,
    ST_RD01,
    ST_RD11,
    ST_RDLAST,
    ST_SUM0,
    ST_SUM1,
    ST_OUT
  } bis_state_e;

  // Multiply-accumulate steps of the blend lanes
  typedef enum logic [2:0] {
    BLEND_TOP_LO,
    BLEND_TOP_HI,
    BLEND_BOT_LO,
    BLEND_BOT_HI,
    BLEND_SUM_LO,
    BLEND_SUM_HI
  } blend_step_e;

  typedef struct packed {
    logic        en;
    blend_step_e step;
  } blend_ctl_t;

  // Horizontal and vertical weights of one target pixel
  typedef struct packed {
    logic [WeightW-1:0] wx0;
    logic [WeightW-1:0] wx1;
    logic [WeightW-1:0] wy0;
    logic [WeightW-1:0] wy1;
  } blend_wgt_t;

  // Dimension minus one, with zero read as one and values above the limit
  // read as the limit.
  function automatic logic [CoordW-1:0] dim_m1(logic [DimW-1:0] v, logic [DimW-1:0] lim);
    logic [CoordW-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v > lim) begin
      r = CoordW'(lim - DimW'(1));
    end else begin
      r = CoordW'(v - DimW'(1));
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/bis_coord_div.sv =====
// ============================================================================
// Coordinate divider
// Restoring divider, one quotient bit per cycle, for ((src-1)*t << F) / d.
// ============================================================================
module bis_coord_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bis_pkg::ProdW-1:0]   num_i,
  input  logic [bis_pkg::CoordW-1:0]  den_i,
  output logic                        busy_o,
  output logic [bis_pkg::QuotW-1:0]   quot_o
);

  localparam int NumW = bis_pkg::ProdW + bis_pkg::FracBits;

  logic [NumW-1:0]                  num_full;
  logic [bis_pkg::CoordW-1:0]       rem_q, rem_d;
  logic [bis_pkg::QuotW-1:0]        sh_q, sh_d;
  logic [bis_pkg::CoordW-1:0]       den_q;
  logic [bis_pkg::DivCntW-1:0]      cnt_q, cnt_d;
  logic                             busy_q, busy_d;
  logic [bis_pkg::CoordW:0]         trial;
  logic [bis_pkg::CoordW:0]         diff;
  logic                             ge;

  assign num_full = {num_i, bis_pkg::FracBits'(0)};

  // One trial subtraction per cycle. The quotient always fits QuotW bits,
  // so the top numerator bits load straight into the remainder.
  assign trial = {rem_q, sh_q[bis_pkg::QuotW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_comb begin
    rem_d  = rem_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = num_full[NumW-1:bis_pkg::QuotW];
      sh_d   = num_full[bis_pkg::QuotW-1:0];
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[bis_pkg::CoordW-1:0] : trial[bis_pkg::CoordW-1:0];
      sh_d  = {sh_q[bis_pkg::QuotW-2:0], ge};
      cnt_d = cnt_q + bis_pkg::DivCntW'(1);
      if (cnt_q == bis_pkg::DivCntW'(bis_pkg::QuotW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = sh_q;

endmodule

// ===== hw/rtl/bis_pixel_store.sv =====
// ============================================================================
// Pixel store
// Single-port synchronous frame memory with a registered read.
// ============================================================================
module bis_pixel_store (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic                       we_i,
  input  logic [bis_pkg::AddrW-1:0]  addr_i,
  input  logic [bis_pkg::PixW-1:0]   wdata_i,
  output logic [bis_pkg::PixW-1:0]   rdata_o
);

  localparam int Depth = 1 << bis_pkg::AddrW;

  logic [bis_pkg::PixW-1:0] mem_q [Depth];
  logic [bis_pkg::PixW-1:0] rdata_q;

  // One access per cycle: either a write or a read.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/bis_blend_unit.sv =====
// ============================================================================
// Blend unit
// Three channel lanes, each a multiply-accumulate that blends four pixels.
// ============================================================================
module bis_blend_unit (
  input  logic                      clk_i,
  input  bis_pkg::blend_ctl_t       ctl_i,
  input  bis_pkg::blend_wgt_t       wgt_i,
  input  logic [bis_pkg::PixW-1:0]  pix_i,
  output logic [bis_pkg::PixW-1:0]  result_o
);

  localparam int MulW = bis_pkg::LineW + bis_pkg::WeightW;
  localparam logic [bis_pkg::SumW-1:0] Half =
    bis_pkg::SumW'(1) << (2 * bis_pkg::FracBits - 1);

  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic [bis_pkg::ChanW-1:0]   chan;
    logic [bis_pkg::LineW-1:0]   op_a;
    logic [bis_pkg::WeightW-1:0] op_b;
    logic [MulW-1:0]             prod;
    logic [bis_pkg::LineW-1:0]   top_q, bot_q;
    logic [bis_pkg::SumW-1:0]    sum_q;
    logic [bis_pkg::SumW-1:0]    rounded;

    assign chan = pix_i[k*bis_pkg::ChanW +: bis_pkg::ChanW];

    // Operand selection for the lane multiplier
    always_comb begin
      op_a = bis_pkg::LineW'(chan);
      op_b = wgt_i.wx0;
      case (ctl_i.step)
        bis_pkg::BLEND_TOP_LO, bis_pkg::BLEND_BOT_LO: begin
          op_b = wgt_i.wx0;
        end
        bis_pkg::BLEND_TOP_HI, bis_pkg::BLEND_BOT_HI: begin
          op_b = wgt_i.wx1;
        end
        bis_pkg::BLEND_SUM_LO: begin
          op_a = top_q;
          op_b = wgt_i.wy0;
        end
        bis_pkg::BLEND_SUM_HI: begin
          op_a = bot_q;
          op_b = wgt_i.wy1;
        end
        default: begin
          op_b = wgt_i.wx0;
        end
      endcase
    end

    assign prod = MulW'(op_a) * MulW'(op_b);

    // Accumulators for the top row, bottom row and final sum
    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        case (ctl_i.step)
          bis_pkg::BLEND_TOP_LO: top_q <= prod[bis_pkg::LineW-1:0];
          bis_pkg::BLEND_TOP_HI: top_q <= top_q + prod[bis_pkg::LineW-1:0];
          bis_pkg::BLEND_BOT_LO: bot_q <= prod[bis_pkg::LineW-1:0];
          bis_pkg::BLEND_BOT_HI: bot_q <= bot_q + prod[bis_pkg::LineW-1:0];
          bis_pkg::BLEND_SUM_LO: sum_q <= prod[bis_pkg::SumW-1:0];
          bis_pkg::BLEND_SUM_HI: sum_q <= sum_q + prod[bis_pkg::SumW-1:0];
          default: sum_q <= sum_q;
        endcase
      end
    end

    // Round half up and keep the integer part.
    assign rounded = sum_q + Half;
    assign result_o[k*bis_pkg::ChanW +: bis_pkg::ChanW] =
      rounded[bis_pkg::SumW-1 -: bis_pkg::ChanW];
  end

endmodule

// ===== hw/rtl/bilinear_image_scaler.sv =====
// ============================================================================
// Bilinear image scaler
// Stores a source RGB frame and returns bilinearly scaled target pixels.
// ============================================================================
// Usage:
// The slave channel carries one item per transfer; tuser selects a pixel
// write (0) or a target pixel request (1). A write stores one source pixel
// and returns nothing; a request returns one RGB result on the master
// channel. The configuration port sets the source and target dimensions
// and must be written only while the block is idle; the block itself
// does not enforce this. Writes can follow each other back to back. A
// request first forms the coordinate products, then runs the bit-serial
// coordinate dividers (25 quotient bits, one per cycle, row and column in
// parallel) until both finish, then makes the four neighbor reads through
// the single memory port, and then finishes the per-channel
// multiply-accumulate and loads the output register. The next item is
// taken only once the sequencer is back in idle, so a request is finished
// before the next item is accepted. tready is high whenever the sequencer
// is idle, also while a finished result waits in the output register. When
// the receiver stalls, the next request completes and waits for that register.
// Reset sets all dimensions to one and empties the output register; the
// pixel store is not cleared and must be written before it is read.
// ============================================================================
module bilinear_image_scaler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Items in. tdata: col_index[8:0], row_index[17:9], red_in[25:18],
  // green_in[33:26], blue_in[41:34], zero fill [47:42]
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [bis_pkg::InDataW-1:0]   s_axis_tdata_i,
  // tuser: cmd[0]
  input  logic [0:0]                    s_axis_tuser_i,
  // Results out. tdata: red_out[7:0], green_out[15:8], blue_out[23:16]
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [bis_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // Configuration writes
  input  logic                          cfg_we_i,
  input  logic [bis_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bis_pkg::DimW-1:0]      cfg_data_i
);

  localparam int CW = bis_pkg::CoordW;
  localparam int F  = bis_pkg::FracBits;

  // Configuration registers
  logic [bis_pkg::DimW-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= bis_pkg::DimW'(1);
      src_h_q <= bis_pkg::DimW'(1);
      dst_w_q <= bis_pkg::DimW'(1);
      dst_h_q <= bis_pkg::DimW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bis_pkg::RegSrcWidth:  src_w_q <= cfg_data_i;
        bis_pkg::RegSrcHeight: src_h_q <= cfg_data_i;
        bis_pkg::RegDstWidth:  dst_w_q <= cfg_data_i;
        bis_pkg::RegDstHeight: dst_h_q <= cfg_data_i;
        default: src_w_q <= src_w_q;
      endcase
    end
  end

  // Effective dimensions minus one
  logic [CW-1:0] sw_m1, sh_m1, dw_m1, dh_m1;

  assign sw_m1 = bis_pkg::dim_m1(src_w_q, bis_pkg::DimW'(bis_pkg::MaxCols));
  assign sh_m1 = bis_pkg::dim_m1(src_h_q, bis_pkg::DimW'(bis_pkg::MaxRows));
  assign dw_m1 = bis_pkg::dim_m1(dst_w_q, bis_pkg::DimW'(bis_pkg::MaxCols));
  assign dh_m1 = bis_pkg::dim_m1(dst_h_q, bis_pkg::DimW'(bis_pkg::MaxRows));

  // Input fields
  logic          in_cmd;
  logic [CW-1:0] in_col, in_row;
  logic [bis_pkg::PixW-1:0] in_pix;
  logic          s_fire;

  assign in_cmd = s_axis_tuser_i[0];
  assign in_col = s_axis_tdata_i[CW-1:0];
  assign in_row = s_axis_tdata_i[2*CW-1:CW];
  assign in_pix = s_axis_tdata_i[2*CW +: bis_pkg::PixW];
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;

  // Sequencer and request registers
  bis_pkg::bis_state_e state_q, state_d;
  logic [CW-1:0] col_q, row_q;
  logic          zero_x_q, zero_y_q;

  // Coordinate products, saturated target index times source span
  logic [CW-1:0]             tx_sat, ty_sat;
  logic [bis_pkg::ProdW-1:0] prod_x, prod_y;

  assign tx_sat = (col_q > dw_m1) ? dw_m1 : col_q;
  assign ty_sat = (row_q > dh_m1) ? dh_m1 : row_q;
  assign prod_x = {{CW{1'b0}}, sw_m1} * {{CW{1'b0}}, tx_sat};
  assign prod_y = {{CW{1'b0}}, sh_m1} * {{CW{1'b0}}, ty_sat};

  logic                      div_start;
  logic                      busy_x, busy_y;
  logic [bis_pkg::QuotW-1:0] quot_x, quot_y;

  assign div_start = (state_q == bis_pkg::ST_MUL);

  bis_coord_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_x),
    .den_i   (dw_m1),
    .busy_o  (busy_x),
    .quot_o  (quot_x)
  );

  bis_coord_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_y),
    .den_i   (dh_m1),
    .busy_o  (busy_y),
    .quot_o  (quot_y)
  );

  // Neighbor coordinates and weights; a target dimension of one maps to 0.
  logic [bis_pkg::QuotW-1:0] cx, cy;
  logic [CW-1:0]             x0, x1, y0, y1;
  logic [F-1:0]              fx, fy;
  bis_pkg::blend_wgt_t       wgt;

  assign cx = zero_x_q ? '0 : quot_x;
  assign cy = zero_y_q ? '0 : quot_y;
  assign x0 = cx[bis_pkg::QuotW-1:F];
  assign y0 = cy[bis_pkg::QuotW-1:F];
  assign fx = cx[F-1:0];
  assign fy = cy[F-1:0];
  assign x1 = (fx != '0) ? x0 + CW'(1) : x0;
  assign y1 = (fy != '0) ? y0 + CW'(1) : y0;

  assign wgt.wx0 = bis_pkg::WeightW'(bis_pkg::FixOne) - bis_pkg::WeightW'(fx);
  assign wgt.wx1 = bis_pkg::WeightW'(fx);
  assign wgt.wy0 = bis_pkg::WeightW'(bis_pkg::FixOne) - bis_pkg::WeightW'(fy);
  assign wgt.wy1 = bis_pkg::WeightW'(fy);

  // Memory port and blend control
  logic                      mem_en, mem_we;
  logic [bis_pkg::AddrW-1:0] mem_addr;
  logic [bis_pkg::PixW-1:0]  mem_rdata;
  bis_pkg::blend_ctl_t       blend_ctl;
  logic [bis_pkg::PixW-1:0]  blend_res;
  logic                      out_load;
  logic                      m_valid_q, m_valid_d;
  logic [bis_pkg::OutDataW-1:0] m_data_q;

  bis_pixel_store u_store (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (in_pix),
    .rdata_o (mem_rdata)
  );

  bis_blend_unit u_blend (
    .clk_i    (clk_i),
    .ctl_i    (blend_ctl),
    .wgt_i    (wgt),
    .pix_i    (mem_rdata),
    .result_o (blend_res)
  );

  // Next state and control outputs
  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    mem_en          = 1'b0;
    mem_we          = 1'b0;
    mem_addr        = {y0, x0};
    blend_ctl.en    = 1'b0;
    blend_ctl.step  = bis_pkg::BLEND_TOP_LO;
    out_load        = 1'b0;
    case (state_q)
      bis_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        mem_addr        = {in_row, in_col};
        if (s_fire) begin
          if (in_cmd == bis_pkg::CmdWrite) begin
            mem_en = 1'b1;
            mem_we = 1'b1;
          end else begin
            state_d = bis_pkg::ST_MUL;
          end
        end
      end
      bis_pkg::ST_MUL: begin
        state_d = bis_pkg::ST_DIV;
      end
      bis_pkg::ST_DIV: begin
        if (!busy_x && !busy_y) begin
          state_d = bis_pkg::ST_RD00;
        end
      end
      bis_pkg::ST_RD00: begin
        mem_en   = 1'b1;
        mem_addr = {y0, x0};
        state_d  = bis_pkg::ST_RD10;
      end
      bis_pkg::ST_RD10: begin
        mem_en         = 1'b1;
        mem_addr       = {y0, x1};
        blend_ctl.en   = 1'b1;
        blend_ctl.step = bis_pkg::BLEND_TOP_LO;
        state_d        = bis_pkg::ST_RD01;
      end
      bis_pkg::ST_RD01: begin
        mem_en         = 1'b1;
        mem_addr       = {y1, x0};
        blend_ctl.en   = 1'b1;
        blend_ctl.step = bis_pkg::BLEND_TOP_HI;
        state_d        = bis_pkg::ST_RD11;
      end
      bis_pkg::ST_RD11: begin
        mem_en         = 1'b1;
        mem_addr       = {y1, x1};
        blend_ctl.en   = 1'b1;
        blend_ctl.step = bis_pkg::BLEND_BOT_LO;
        state_d        = bis_pkg::ST_RDLAST;
      end
      bis_pkg::ST_RDLAST: begin
        blend_ctl.en   = 1'b1;
        blend_ctl.step = bis_pkg::BLEND_BOT_HI;
        state_d        = bis_pkg::ST_SUM0;
      end
      bis_pkg::ST_SUM0: begin
        blend_ctl.en   = 1'b1;
        blend_ctl.step = bis_pkg::BLEND_SUM_LO;
        state_d        = bis_pkg::ST_SUM1;
      end
      bis_pkg::ST_SUM1: begin
        blend_ctl.en   = 1'b1;
        blend_ctl.step = bis_pkg::BLEND_SUM_HI;
        state_d        = bis_pkg::ST_OUT;
      end
      bis_pkg::ST_OUT: begin
        // Wait for the output register to be free.
        if (!m_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = bis_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bis_pkg::ST_IDLE;
      end
    endcase
  end

  assign m_valid_d = (m_valid_q && !m_axis_tready_i) || out_load;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bis_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      col_q <= in_col;
      row_q <= in_row;
    end
    if (state_q == bis_pkg::ST_MUL) begin
      zero_x_q <= (dw_m1 == '0);
      zero_y_q <= (dh_m1 == '0);
    end
    if (out_load) begin
      m_data_q <= blend_res;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

`ifndef SYNTHESIS
  // A request transfer starts the coordinate products in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && in_cmd == bis_pkg::CmdRequest) |=> (state_q == bis_pkg::ST_MUL))
    else $error("request transfer did not start the coordinate mapping");

  // A pixel write transfer leaves the sequencer idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && in_cmd == bis_pkg::CmdWrite) |=> (state_q == bis_pkg::ST_IDLE))
    else $error("pixel write transfer left the sequencer busy");

  // A new result appears only after the output state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == bis_pkg::ST_OUT))
    else $error("result raised outside the output state");

  // The dividers are idle whenever a new item can be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> (!busy_x && !busy_y))
    else $error("coordinate divider busy while the block is idle");
`endif

endmodule
